[hw/rtl/spatial_arm_forward_kinematics_defines.svh]
// ----------------------------------------------------------------------------
// Spatial arm forward kinematics: assertion macros
// Shared concurrent assertion forms. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef SPATIAL_ARM_FORWARD_KINEMATICS_DEFINES_SVH
`define SPATIAL_ARM_FORWARD_KINEMATICS_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SFK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfk assertion failed");
// Next-cycle implication.
`define SFK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfk assertion failed");
`else
`define SFK_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SFK_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/sfk_pkg.sv]
// ----------------------------------------------------------------------------
// Spatial arm forward kinematics package
// Widths, codes, item and state types and the CORDIC angle table.
// ----------------------------------------------------------------------------
package sfk_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int COORD_BITS   = 32;
	localparam int FRAC_BITS    = 16;
	localparam int FRAME_BITS   = FRAC_BITS + 2;
	localparam int CORDIC_STEPS = 18;
	localparam int CW           = 34;
	localparam int STEP_BITS    = 5;
	localparam int PROD_BITS    = COORD_BITS + FRAME_BITS;
	localparam int ACC_BITS     = PROD_BITS + 2;
	localparam int RPROD_BITS   = 2 * FRAME_BITS;
	localparam int CFG_IDX_BITS = 2;

	localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
	localparam logic signed [FRAME_BITS-1:0] FRAME_ONE = 18'sd65536;

	localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_X = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Y = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Z = 2'd2;

	typedef enum logic [1:0] {
		AXIS_X   = 2'd0,
		AXIS_Y   = 2'd1,
		AXIS_Z   = 2'd2,
		AXIS_BAD = 2'd3
	} axis_t;

	typedef struct packed {
		logic                          bad;
		axis_t                         axis;
		logic [ANGLE_BITS-1:0]         angle;
		logic signed [COORD_BITS-1:0]  link_x;
		logic signed [COORD_BITS-1:0]  link_y;
		logic signed [COORD_BITS-1:0]  link_z;
		logic                          chain_end;
	} item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CORDIC,
		S_QUAD,
		S_ROT_MUL,
		S_ROT_ADD,
		S_XF_MUL,
		S_XF_ACC,
		S_POS,
		S_OUT
	} state_t;

	// Arctangent of 2^-i in turns, scaled by 2^32.
	function automatic logic signed [CW-1:0] atan_turn(input logic [STEP_BITS-1:0] i);
		logic signed [CW-1:0] r;
		case (i)
			5'd0:    r = 34'sd536870912;
			5'd1:    r = 34'sd316933406;
			5'd2:    r = 34'sd167458907;
			5'd3:    r = 34'sd85004756;
			5'd4:    r = 34'sd42667331;
			5'd5:    r = 34'sd21354465;
			5'd6:    r = 34'sd10679839;
			5'd7:    r = 34'sd5340245;
			5'd8:    r = 34'sd2670163;
			5'd9:    r = 34'sd1335087;
			5'd10:   r = 34'sd667544;
			5'd11:   r = 34'sd333772;
			5'd12:   r = 34'sd166886;
			5'd13:   r = 34'sd83443;
			5'd14:   r = 34'sd41722;
			5'd15:   r = 34'sd20861;
			5'd16:   r = 34'sd10430;
			5'd17:   r = 34'sd5215;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/sfk_front.sv]
// ----------------------------------------------------------------------------
// Spatial arm forward kinematics: front end
// Accepts joint beats, flags an undefined axis and queues two items.
// ----------------------------------------------------------------------------
module sfk_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [111:0]                         s_tdata,
	input  logic [1:0]                           s_tuser,
	input  logic                                 s_tlast,
	output logic                                 q_valid,
	input  logic                                 q_ready,
	output sfk_pkg::item_t                       q_item
);
	import sfk_pkg::*;

	item_t     slot_q [0:1];
	logic      wr_ptr_q;
	logic      rd_ptr_q;
	logic [1:0] count_q;
	item_t     in_item;
	logic      push;
	logic      pop;

	always_comb begin
		in_item.axis      = axis_t'(s_tuser);
		in_item.bad       = (axis_t'(s_tuser) == AXIS_BAD);
		in_item.angle     = s_tdata[15:0];
		in_item.link_x    = s_tdata[47:16];
		in_item.link_y    = s_tdata[79:48];
		in_item.link_z    = s_tdata[111:80];
		in_item.chain_end = s_tlast;
	end

	assign s_tready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = slot_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/sfk_back.sv]
// ----------------------------------------------------------------------------
// Spatial arm forward kinematics: back end
// Sequencer with CORDIC, frame rotation, link transform and output register.
// ----------------------------------------------------------------------------
`include "spatial_arm_forward_kinematics_defines.svh"

module sfk_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_valid,
	output logic                                 q_ready,
	input  sfk_pkg::item_t                       q_item,
	input  logic signed [sfk_pkg::COORD_BITS-1:0] origin_x,
	input  logic signed [sfk_pkg::COORD_BITS-1:0] origin_y,
	input  logic signed [sfk_pkg::COORD_BITS-1:0] origin_z,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [95:0]                          m_tdata,
	output logic [0:0]                           m_tuser,
	output logic                                 m_tlast
);
	import sfk_pkg::*;

	state_t state_q, state_next;

	item_t                         cur_q;
	logic                          in_chain_q;
	logic signed [FRAME_BITS-1:0]  frame_q [0:2][0:2];
	logic signed [COORD_BITS-1:0]  pos_q [0:2];
	logic signed [CW-1:0]          cx_q, cy_q, cz_q;
	logic [1:0]                    quad_q;
	logic [STEP_BITS-1:0]          step_q;
	logic signed [FRAME_BITS-1:0]  c_q, s_q;
	logic [1:0]                    k_q, j_q;
	logic signed [RPROD_BITS-1:0]  p_ca_q, p_sb_q, p_cb_q, p_sa_q;
	logic signed [PROD_BITS-1:0]   prod_q;
	logic signed [ACC_BITS-1:0]    acc_q;
	logic                          out_valid_q;
	logic [95:0]                   out_data_q;
	logic                          out_last_q, out_bad_q;

	logic                          take;
	logic                          out_load;
	logic [1:0]                    col_a, col_b;
	logic signed [CW-1:0]          dx, dy;
	logic [31:0]                   turn;
	logic [1:0]                    quad;
	logic [1:0]                    zq_hi;
	logic signed [CW-1:0]          cr_full, sr_full;
	logic signed [FRAME_BITS-1:0]  cr, sr;
	logic signed [RPROD_BITS:0]    sum_a, sum_b;
	logic signed [FRAME_BITS-1:0]  new_a, new_b;
	logic signed [FRAME_BITS-1:0]  new_row [0:2];
	logic signed [COORD_BITS-1:0]  link_j;
	logic signed [ACC_BITS-1:0]    rnd;
	logic signed [ACC_BITS:0]      pos_sum;
	logic signed [COORD_BITS-1:0]  pos_new;
	logic signed [COORD_BITS-1:0]  res_x, res_y, res_z;

	function automatic logic signed [FRAME_BITS-1:0] sat_frame(
		input logic signed [RPROD_BITS:0] v
	);
		logic signed [RPROD_BITS:0] hi;
		logic signed [RPROD_BITS:0] lo;
		hi = (RPROD_BITS+1)'((1 <<< (FRAME_BITS - 1)) - 1);
		lo = -hi - 1;
		if (v > hi) begin
			return hi[FRAME_BITS-1:0];
		end else if (v < lo) begin
			return lo[FRAME_BITS-1:0];
		end
		return v[FRAME_BITS-1:0];
	endfunction

	function automatic logic signed [COORD_BITS-1:0] sat_coord(
		input logic signed [ACC_BITS:0] v
	);
		logic signed [ACC_BITS:0] hi;
		logic signed [ACC_BITS:0] lo;
		hi = {{(ACC_BITS - COORD_BITS + 2){1'b0}}, {(COORD_BITS - 1){1'b1}}};
		lo = -hi - 1;
		if (v > hi) begin
			return hi[COORD_BITS-1:0];
		end else if (v < lo) begin
			return lo[COORD_BITS-1:0];
		end
		return v[COORD_BITS-1:0];
	endfunction

	// Column pair rotated for each axis.
	always_comb begin
		col_a = (cur_q.axis == AXIS_X) ? 2'd1 : 2'd0;
		col_b = (cur_q.axis == AXIS_Z) ? 2'd1 : 2'd2;
	end

	// Angle widening and nearest quadrant.
	always_comb begin
		turn  = {q_item.angle, {(32 - ANGLE_BITS){1'b0}}};
		quad  = turn[31:30] + {1'b0, turn[29]};
		zq_hi = turn[31:30] - quad;
	end

	always_comb begin
		dx      = cy_q >>> step_q;
		dy      = cx_q >>> step_q;
		cr_full = (cx_q + (CW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
		sr_full = (cy_q + (CW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
		cr      = cr_full[FRAME_BITS-1:0];
		sr      = sr_full[FRAME_BITS-1:0];
	end

	always_comb begin
		sum_a = (RPROD_BITS+1)'(p_ca_q) + (RPROD_BITS+1)'(p_sb_q)
			+ (RPROD_BITS+1)'(1 <<< (FRAC_BITS - 1));
		sum_b = (RPROD_BITS+1)'(p_cb_q) - (RPROD_BITS+1)'(p_sa_q)
			+ (RPROD_BITS+1)'(1 <<< (FRAC_BITS - 1));
		new_a = sat_frame(sum_a >>> FRAC_BITS);
		new_b = sat_frame(sum_b >>> FRAC_BITS);
		for (int i = 0; i < 3; i++) begin
			new_row[i] = frame_q[0][i];
		end
		new_row[col_a] = new_a;
		new_row[col_b] = new_b;
	end

	always_comb begin
		case (j_q)
			2'd0:    link_j = cur_q.link_x;
			2'd1:    link_j = cur_q.link_y;
			default: link_j = cur_q.link_z;
		endcase
		rnd     = (acc_q + ACC_BITS'(1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		pos_sum = (ACC_BITS+1)'(pos_q[0]) + (ACC_BITS+1)'(rnd);
		pos_new = sat_coord(pos_sum);
	end

	always_comb begin
		if (cur_q.bad && !in_chain_q) begin
			res_x = origin_x;
			res_y = origin_y;
			res_z = origin_z;
		end else begin
			res_x = pos_q[0];
			res_y = pos_q[1];
			res_z = pos_q[2];
		end
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					state_next = q_item.bad ? S_OUT : S_CORDIC;
				end
			end
			S_CORDIC: begin
				if (step_q == STEP_BITS'(CORDIC_STEPS - 1)) begin
					state_next = S_QUAD;
				end
			end
			S_QUAD:    state_next = S_ROT_MUL;
			S_ROT_MUL: state_next = S_ROT_ADD;
			S_ROT_ADD: state_next = (k_q == 2'd2) ? S_XF_MUL : S_ROT_MUL;
			S_XF_MUL:  state_next = S_XF_ACC;
			S_XF_ACC:  state_next = (j_q == 2'd2) ? S_POS : S_XF_MUL;
			S_POS:     state_next = (k_q == 2'd2) ? S_OUT : S_XF_MUL;
			S_OUT: begin
				if (!out_valid_q || m_tready) begin
					state_next = S_IDLE;
				end
			end
			default:   state_next = S_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		q_ready  = 1'b0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE:  q_ready  = 1'b1;
			S_OUT:   out_load = !out_valid_q || m_tready;
			default: begin
				q_ready  = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	assign take = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_chain_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (take && !q_item.bad) begin
				in_chain_q <= 1'b1;
			end else if (out_load && !cur_q.bad && cur_q.chain_end) begin
				in_chain_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (take) begin
					cur_q  <= q_item;
					cx_q   <= CORDIC_X0;
					cy_q   <= '0;
					cz_q   <= {{(CW - 32){zq_hi[1]}}, zq_hi, turn[29:0]};
					quad_q <= quad;
					step_q <= '0;
					k_q    <= 2'd0;
					j_q    <= 2'd0;
					if (!q_item.bad && !in_chain_q) begin
						for (int r = 0; r < 3; r++) begin
							for (int c = 0; c < 3; c++) begin
								frame_q[r][c] <= (r == c) ? FRAME_ONE : '0;
							end
						end
						pos_q[0] <= origin_x;
						pos_q[1] <= origin_y;
						pos_q[2] <= origin_z;
					end
				end
			end
			S_CORDIC: begin
				if (!cz_q[CW-1]) begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					cz_q <= cz_q - atan_turn(step_q);
				end else begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					cz_q <= cz_q + atan_turn(step_q);
				end
				step_q <= step_q + STEP_BITS'(1);
			end
			S_QUAD: begin
				case (quad_q)
					2'd0: begin
						c_q <= cr;
						s_q <= sr;
					end
					2'd1: begin
						c_q <= -sr;
						s_q <= cr;
					end
					2'd2: begin
						c_q <= -cr;
						s_q <= -sr;
					end
					default: begin
						c_q <= sr;
						s_q <= -cr;
					end
				endcase
			end
			S_ROT_MUL: begin
				p_ca_q <= c_q * frame_q[0][col_a];
				p_sb_q <= s_q * frame_q[0][col_b];
				p_cb_q <= c_q * frame_q[0][col_b];
				p_sa_q <= s_q * frame_q[0][col_a];
			end
			S_ROT_ADD: begin
				// Rows circulate so that row 0 is always the one being worked on.
				frame_q[0] <= frame_q[1];
				frame_q[1] <= frame_q[2];
				frame_q[2] <= new_row;
				k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
			end
			S_XF_MUL: begin
				prod_q <= link_j * frame_q[0][j_q];
			end
			S_XF_ACC: begin
				acc_q <= (j_q == 2'd0) ? ACC_BITS'(prod_q) : acc_q + ACC_BITS'(prod_q);
				j_q   <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
			end
			S_POS: begin
				pos_q[0]   <= pos_q[1];
				pos_q[1]   <= pos_q[2];
				pos_q[2]   <= pos_new;
				frame_q[0] <= frame_q[1];
				frame_q[1] <= frame_q[2];
				frame_q[2] <= frame_q[0];
				k_q        <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
			end
			S_OUT: begin
				if (out_load) begin
					out_data_q <= {res_z, res_y, res_x};
					out_last_q <= cur_q.chain_end && !cur_q.bad;
					out_bad_q  <= cur_q.bad;
				end
			end
			default: begin
				k_q <= 2'd0;
			end
		endcase
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tlast    = out_last_q;
	assign m_tuser[0] = out_bad_q;

	`SFK_ASSERT_NXT(a_take_leaves_idle, clk, arst_n, take, state_q != S_IDLE)
	`SFK_ASSERT_NXT(a_cordic_runs, clk, arst_n,
		state_q == S_CORDIC && step_q != STEP_BITS'(CORDIC_STEPS - 1), state_q == S_CORDIC)
	`SFK_ASSERT_NXT(a_result_only_from_out, clk, arst_n,
		state_q != S_OUT && !out_valid_q, !out_valid_q)
	`SFK_ASSERT_IMP(a_busy_not_ready, clk, arst_n, state_q != S_IDLE, !q_ready)

endmodule

[hw/rtl/spatial_arm_forward_kinematics.sv]
// ----------------------------------------------------------------------------
// Spatial arm forward kinematics
// Serial-chain forward kinematics in 3D: one revolute joint per input beat,
// one running end position per output beat.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Beat contents
// s_*       in         tdata: angle, link_x, link_y, link_z; tuser: axis;
//                      tlast: chain_end
// m_*       out        tdata: end_x, end_y, end_z; tuser: bad_axis;
//                      tlast: final_res
// cfg_*     in         write of origin_x (0), origin_y (1), origin_z (2)
//
// In the back end a valid joint runs 18 CORDIC iterations, three row
// rotations and nine multiply-accumulate pairs on one 50-bit multiplier,
// plus three position updates. An undefined axis goes straight to output.
// The front queue holds two joints, and the output register lets the back end
// start the next joint while a result waits to be taken.
// Reset clears the control state and ends any open chain; no clearing pass.
// A stalled output holds the back end only at the point where it would
// write the next result.
//
// The frame is kept as three rows that circulate through one working row.
// Position update saturates to 32 bits; frame entries saturate to 18 bits.
module spatial_arm_forward_kinematics (
	input  logic         clk,
	input  logic         arst_n,
	// Joint beats. tdata from bit 0: angle[15:0], link_x[47:16],
	// link_y[79:48], link_z[111:80].
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,
	// tuser from bit 0: axis[1:0].
	input  logic [1:0]   s_tuser,
	input  logic         s_tlast,
	// Result beats. tdata from bit 0: end_x[31:0], end_y[63:32], end_z[95:64].
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,
	// tuser from bit 0: bad_axis[0].
	output logic [0:0]   m_tuser,
	output logic         m_tlast,
	// Configuration writes.
	input  logic         cfg_we,
	input  logic [sfk_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [31:0]  cfg_wdata
);
	import sfk_pkg::*;

	logic signed [COORD_BITS-1:0] origin_x_q, origin_y_q, origin_z_q;
	logic  q_valid;
	logic  q_ready;
	item_t q_item;

	// Origin registers; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ORIGIN_X: origin_x_q <= cfg_wdata;
				CFG_ORIGIN_Y: origin_y_q <= cfg_wdata;
				CFG_ORIGIN_Z: origin_z_q <= cfg_wdata;
				default: begin
					origin_x_q <= origin_x_q;
				end
			endcase
		end
	end

	// Front end: accepts beats, classifies the axis and queues them.
	sfk_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	// Back end: sine and cosine, frame rotation, link transform, result.
	sfk_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item),
		.origin_x (origin_x_q),
		.origin_y (origin_y_q),
		.origin_z (origin_z_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

[tb/spatial_arm_forward_kinematics_checker.sv]
// ----------------------------------------------------------------------------
// Spatial arm forward kinematics result checker
// Watches the joint and result channels and the configuration port. It keeps
// its own copy of the frame, the position and the origin, predicts the result
// beat for every accepted joint and compares each result beat with it.
// ----------------------------------------------------------------------------
module spatial_arm_forward_kinematics_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [111:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [95:0]  m_tdata,
	input  logic [0:0]   m_tuser,
	input  logic         m_tlast,
	input  logic         cfg_we,
	input  logic [sfk_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [31:0]  cfg_wdata,
	output int           fail_count,
	output int           pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import sfk_pkg::*;

	typedef struct {
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] end_z;
		logic               final_res;
		logic               bad_axis;
	} position_beat_t;

	position_beat_t position_queue[$];

	longint frame_m[9];
	longint pos_m[3];
	longint origin_m[3];
	bit     chain_open;

	// Turn-unit arctangents scaled by 2^32; kept locally for the predictor.
	longint atan_tab[18] = '{536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679839, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215};

	function automatic longint clamp(longint v, int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	// Sine and cosine of a 16-bit turn fraction, Q1.16.
	task automatic sine_cosine(input logic [15:0] angle, output longint c, output longint s);
		logic [31:0] t;
		logic [1:0]  q;
		logic [31:0] rem;
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		longint cr;
		longint sr;
		t = {angle, 16'h0};
		q = 2'((t + 32'h2000_0000) >> 30);
		rem = t - (32'(q) << 30);
		z = longint'($signed(rem));
		x = 652032874;
		y = 0;
		for (int i = 0; i < 18; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tab[i];
			end else begin
				x += dx; y -= dy; z += atan_tab[i];
			end
		end
		cr = (x + (longint'(1) <<< 13)) >>> 14;
		sr = (y + (longint'(1) <<< 13)) >>> 14;
		case (q)
			2'd0: begin c = cr; s = sr; end
			2'd1: begin c = -sr; s = cr; end
			2'd2: begin c = -cr; s = -sr; end
			default: begin c = sr; s = -cr; end
		endcase
	endtask

	task automatic turn_columns(input int a, input int b, input longint c, input longint s);
		longint va;
		longint vb;
		for (int k = 0; k < 3; k++) begin
			va = frame_m[a * 3 + k];
			vb = frame_m[b * 3 + k];
			frame_m[a * 3 + k] = clamp((c * va + s * vb + 32768) >>> 16, 18);
			frame_m[b * 3 + k] = clamp((c * vb - s * va + 32768) >>> 16, 18);
		end
	endtask

	task automatic predict_joint(input axis_t axis, input logic [15:0] angle,
			input logic [111:0] data, input logic last);
		position_beat_t r;
		longint c;
		longint s;
		longint link[3];
		longint hsum;
		longint lsum;
		longint f;
		r.final_res = 1'b0;
		r.bad_axis = (axis == AXIS_BAD);
		if (axis == AXIS_BAD) begin
			r.end_x = chain_open ? pos_m[0] : origin_m[0];
			r.end_y = chain_open ? pos_m[1] : origin_m[1];
			r.end_z = chain_open ? pos_m[2] : origin_m[2];
		end else begin
			if (!chain_open) begin
				for (int k = 0; k < 9; k++)
					frame_m[k] = (k % 4 == 0) ? 65536 : 0;
				for (int k = 0; k < 3; k++)
					pos_m[k] = origin_m[k];
				chain_open = 1'b1;
			end
			sine_cosine(angle, c, s);
			case (axis)
				AXIS_X: turn_columns(1, 2, c, s);
				AXIS_Y: turn_columns(0, 2, c, s);
				default: turn_columns(0, 1, c, s);
			endcase
			for (int j = 0; j < 3; j++)
				link[j] = longint'($signed(data[16 + 32 * j +: 32]));
			for (int k = 0; k < 3; k++) begin
				hsum = 0;
				lsum = 0;
				for (int j = 0; j < 3; j++) begin
					f = frame_m[j * 3 + k];
					hsum += (link[j] >>> 16) * f;
					lsum += (link[j] & 64'hFFFF) * f;
				end
				hsum += (lsum + 32768) >>> 16;
				pos_m[k] = clamp(pos_m[k] + hsum, 32);
			end
			if (last) begin
				r.final_res = 1'b1;
				chain_open = 1'b0;
			end
			r.end_x = pos_m[0];
			r.end_y = pos_m[1];
			r.end_z = pos_m[2];
		end
		position_queue = {position_queue, r};
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		chain_open = 1'b0;
		for (int k = 0; k < 3; k++) begin
			origin_m[k] = 0;
			pos_m[k] = 0;
		end
		for (int k = 0; k < 9; k++)
			frame_m[k] = (k % 4 == 0) ? 65536 : 0;
	end

	always @(posedge clk) begin
		position_beat_t e;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ORIGIN_X: origin_m[0] = longint'($signed(cfg_wdata));
					CFG_ORIGIN_Y: origin_m[1] = longint'($signed(cfg_wdata));
					CFG_ORIGIN_Z: origin_m[2] = longint'($signed(cfg_wdata));
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_joint(axis_t'(s_tuser), s_tdata[15:0], s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (position_queue.size() == 0) begin
					report_mismatch("unexpected result beat", 0, 0);
				end else begin
					e = position_queue.pop_front();
					if ($signed(m_tdata[31:0]) != e.end_x)
						report_mismatch("end_x", $signed(m_tdata[31:0]), e.end_x);
					if ($signed(m_tdata[63:32]) != e.end_y)
						report_mismatch("end_y", $signed(m_tdata[63:32]), e.end_y);
					if ($signed(m_tdata[95:64]) != e.end_z)
						report_mismatch("end_z", $signed(m_tdata[95:64]), e.end_z);
					if (m_tlast != e.final_res)
						report_mismatch("final_res", m_tlast, e.final_res);
					if (m_tuser[0] != e.bad_axis)
						report_mismatch("bad_axis", m_tuser[0], e.bad_axis);
				end
			end
			pending = position_queue.size();
		end
	end
endmodule

[tb/spatial_arm_forward_kinematics_test.sv]
// ----------------------------------------------------------------------------
// Spatial arm forward kinematics testbench
// Drives directed and random joint chains with random idling on both sides,
// rewrites the origin between phases and leaves all checking to the checker.
// ----------------------------------------------------------------------------
module spatial_arm_forward_kinematics_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sfk_pkg::*;

	// The settle pause covers the back-end work of several joints.
	localparam int SETTLE_CYCLES = 200;
	// Worst case between two accepted beats: a full stall burst plus a joint.
	localparam int STALL_LIMIT = 5000;
	localparam int RANDOM_JOINTS = 1880;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [95:0]  m_tdata;
	logic [0:0]   m_tuser;
	logic         m_tlast;
	logic         cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [31:0]  cfg_wdata = '0;
	int           fail_count;
	int           pending;
	// When set, both sides run without idling (the closing part of the run).
	bit           steady = 1'b0;
	int           quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	spatial_arm_forward_kinematics dut (.*);

	spatial_arm_forward_kinematics_checker checker_i (.*);

	// The receiver stalls in random bursts, except in the closing part of the
	// run where it always takes the result beat.
	initial begin
		int burst;
		@(posedge arst_n);
		forever begin
			burst = $urandom_range(1, 18);
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			if (!steady && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat (burst) @(posedge clk);
			end
		end
	end

	// Watchdog: a long run of cycles with no accepted beat ends the run.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Sends one joint beat and holds it until accepted; the sender may then
	// pause for a random burst before the next beat.
	task automatic send_joint(input axis_t axis, input logic [15:0] angle,
			input logic [31:0] lx, input logic [31:0] ly, input logic [31:0] lz,
			input logic last);
		s_tvalid <= 1'b1;
		s_tuser <= axis;
		s_tdata <= {lz, ly, lx, angle};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (!steady && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// Drops valid and waits until every predicted result has been taken,
	// then lets the block settle so that origin writes meet an idle block.
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_origin(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ORIGIN_X;
		cfg_wdata <= x;
		@(posedge clk);
		cfg_index <= CFG_ORIGIN_Y;
		cfg_wdata <= y;
		@(posedge clk);
		cfg_index <= CFG_ORIGIN_Z;
		cfg_wdata <= z;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Random link component: mostly modest lengths, sometimes full range.
	function automatic logic [31:0] pick_link();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom;
			1: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: v = 32'($signed(17'($urandom_range(0, 131071))) <<< 8);
		endcase
		return v;
	endfunction

	function automatic logic [31:0] pick_origin();
		case ($urandom_range(0, 3))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		axis_t axis;
		int chain_len;
		int sent;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: undefined axis before any chain, every axis, the
		// quadrant boundaries of the angle and the link extremes.
		send_joint(AXIS_BAD, 16'h1234, 32'h0001_0000, 32'h0, 32'h0, 1'b1);
		send_joint(AXIS_X, 16'h0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
		send_joint(AXIS_Y, 16'h4000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_joint(AXIS_BAD, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_joint(AXIS_Z, 16'h8000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
		send_joint(AXIS_Z, 16'hC000, 32'h0, 32'h0, 32'h0, 1'b1);
		send_joint(AXIS_X, 16'h2000, 32'h0001_0000, 32'h0, 32'h0, 1'b0);
		send_joint(AXIS_Y, 16'hE000, 32'h0000_8000, 32'hFFFF_8000, 32'h1, 1'b0);
		send_joint(AXIS_Z, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0);
		send_joint(AXIS_X, 16'h5FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		send_joint(AXIS_X, 16'h6000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		send_joint(AXIS_Y, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 1'b1);
		send_joint(AXIS_BAD, 16'h0, 32'h0, 32'h0, 32'h0, 1'b0);
		drain();

		// Extreme origins, then a closed chain pushing into saturation.
		write_origin(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_joint(AXIS_BAD, 16'h0, 32'h0, 32'h0, 32'h0, 1'b0);
		send_joint(AXIS_X, 16'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_joint(AXIS_BAD, 16'h0, 32'h0, 32'h0, 32'h0, 1'b0);
		send_joint(AXIS_Z, 16'h8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		drain();
		write_origin(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);

		// Random chains with random content, a few stray undefined axes, and
		// an origin change with a full drain every few hundred joints.
		sent = 0;
		while (sent < RANDOM_JOINTS) begin
			if (sent > RANDOM_JOINTS - 150)
				steady = 1'b1;
			chain_len = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) :
				$urandom_range(1, 8);
			for (int j = 0; j < chain_len; j++) begin
				axis = $urandom_range(0, 15) == 0 ? AXIS_BAD : axis_t'($urandom_range(0, 2));
				send_joint(axis, 16'($urandom), pick_link(), pick_link(), pick_link(),
					(j == chain_len - 1) ? 1'b1 : 1'($urandom_range(0, 20) == 0));
				sent++;
			end
			if (!steady && $urandom_range(0, 40) == 0) begin
				drain();
				write_origin(pick_origin(), pick_origin(), pick_origin());
			end
		end
		drain();
		write_origin(32'h0, 32'h0, 32'h0);
		send_joint(AXIS_Y, 16'h3000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
		drain();

		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
